/* rtl/assert_macros.svh */
// assertion macros used by longest_line_run_finder
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/llrf_pkg.sv */
// package for the longest line run finder: sizes, register codes, store types
// no dependencies
package llrf_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int POS_W    = 10;
    localparam int DIM_W    = 11;
    localparam int IDX_W    = 2;
    localparam int IN_W     = 8;
    localparam int OUT_W    = 88;

    localparam logic [IDX_W-1:0] REG_FRAME_COLS = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_ROWS = 2'd1;

    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] addr;
        logic [DIM_W-1:0] data;
    } col_wr_t;

    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] addr;
    } col_rd_t;

endpackage

/* rtl/longest_line_run_finder.sv */
// longest horizontal and vertical line of ones in a raster-order bitmap
// depends on llrf_pkg, llrf_col_ram and assert_macros.svh
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata: pixel
//  m_        out  m_tvalid/m_tready  m_tdata: one result word per bitmap
//  cfg_      in   cfg_valid/ready    cfg_index, cfg_data
//
// one pixel per cycle while not stalled, two-stage pipeline: column store read, then update
// the column store read-modify-write sets the rate; back-to-back hits on
// one column are forwarded
// result word is registered when the last pixel of the bitmap leaves the update stage
// input stalls only when a finished bitmap meets a full output register
// reset: synchronous, active low; column store needs no clearing
module longest_line_run_finder
    import llrf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // pixel
    output logic             m_tvalid,
    input  logic             m_tready,
    // h_found, h_row, h_start_col, h_end_col, h_length,
    // v_found, v_col, v_start_row, v_end_row, v_length
    output logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0] cfg_data
);

`include "assert_macros.svh"

    logic [DIM_W-1:0] frame_cols_reg, frame_rows_reg;
    logic [DIM_W-1:0] cols, rows;

    logic [POS_W-1:0] cur_col_reg, cur_col_next;
    logic [POS_W-1:0] cur_row_reg, cur_row_next;

    logic             s1_valid_reg, s1_valid_next;
    logic             s1_pixel_reg, s1_frame_end_reg;
    logic [POS_W-1:0] s1_col_reg, s1_row_reg;
    logic             fwd_hit_reg;
    logic [DIM_W-1:0] fwd_data_reg;

    logic [DIM_W-1:0] row_run_reg, row_run_next;
    logic [DIM_W-1:0] best_h_len_reg, best_h_len_next;
    logic [POS_W-1:0] best_h_row_reg, best_h_row_next;
    logic [POS_W-1:0] best_h_end_reg, best_h_end_next;
    logic [DIM_W-1:0] best_v_len_reg, best_v_len_next;
    logic [POS_W-1:0] best_v_col_reg, best_v_col_next;
    logic [POS_W-1:0] best_v_end_reg, best_v_end_next;

    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;

    logic             accept, stall, s1_fire;
    logic             row_end, frame_end;
    logic [DIM_W-1:0] ram_rd_data, old_v, vrun, hrun;
    logic [DIM_W-1:0] h_len_o, v_len_o;
    logic [POS_W-1:0] h_start, v_start;
    col_wr_t          col_wr;
    col_rd_t          col_rd;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_cols_reg <= DIM_W'(MAX_COLS);
            frame_rows_reg <= DIM_W'(MAX_ROWS);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FRAME_COLS: frame_cols_reg <= cfg_data;
                REG_FRAME_ROWS: frame_rows_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (frame_cols_reg == '0) begin
            cols = DIM_W'(1);
        end else if (frame_cols_reg > DIM_W'(MAX_COLS)) begin
            cols = DIM_W'(MAX_COLS);
        end else begin
            cols = frame_cols_reg;
        end
        if (frame_rows_reg == '0) begin
            rows = DIM_W'(1);
        end else if (frame_rows_reg > DIM_W'(MAX_ROWS)) begin
            rows = DIM_W'(MAX_ROWS);
        end else begin
            rows = frame_rows_reg;
        end
    end

    // handshake
    assign stall    = s1_valid_reg && s1_frame_end_reg && out_valid_reg && !m_tready;
    assign s1_fire  = s1_valid_reg && !stall;
    assign s_tready = !stall;
    assign accept   = s_tvalid && s_tready;

    // stage 0: position counters and store read
    assign row_end   = ({1'b0, cur_col_reg} + DIM_W'(1)) >= cols;
    assign frame_end = row_end && (({1'b0, cur_row_reg} + DIM_W'(1)) >= rows);

    always_comb begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        if (accept) begin
            if (frame_end) begin
                cur_col_next = '0;
                cur_row_next = '0;
            end else if (row_end) begin
                cur_col_next = '0;
                cur_row_next = cur_row_reg + POS_W'(1);
            end else begin
                cur_col_next = cur_col_reg + POS_W'(1);
            end
        end
    end

    assign col_rd.en   = accept;
    assign col_rd.addr = cur_col_reg;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end
    end

    // stage 1: run update and store write-back
    assign old_v = fwd_hit_reg ? fwd_data_reg : ram_rd_data;

    always_comb begin
        if (!s1_pixel_reg) begin
            vrun = '0;
        end else if (s1_row_reg == '0) begin
            vrun = DIM_W'(1);
        end else begin
            vrun = old_v + DIM_W'(1);
        end
        if (!s1_pixel_reg) begin
            hrun = '0;
        end else if (s1_col_reg == '0) begin
            hrun = DIM_W'(1);
        end else begin
            hrun = row_run_reg + DIM_W'(1);
        end
    end

    assign col_wr.en   = s1_fire;
    assign col_wr.addr = s1_col_reg;
    assign col_wr.data = vrun;

    always_comb begin
        best_h_len_next = best_h_len_reg;
        best_h_row_next = best_h_row_reg;
        best_h_end_next = best_h_end_reg;
        best_v_len_next = best_v_len_reg;
        best_v_col_next = best_v_col_reg;
        best_v_end_next = best_v_end_reg;
        if (hrun > best_h_len_reg) begin
            best_h_len_next = hrun;
            best_h_row_next = s1_row_reg;
            best_h_end_next = s1_col_reg;
        end
        if (vrun > best_v_len_reg ||
            (vrun != '0 && vrun == best_v_len_reg && s1_col_reg < best_v_col_reg)) begin
            best_v_len_next = vrun;
            best_v_col_next = s1_col_reg;
            best_v_end_next = s1_row_reg;
        end
    end

    // result word
    assign h_len_o = best_h_len_next;
    assign v_len_o = best_v_len_next;
    assign h_start = best_h_end_next + POS_W'(1) - h_len_o[POS_W-1:0];
    assign v_start = best_v_end_next + POS_W'(1) - v_len_o[POS_W-1:0];

    always_comb begin
        out_data_next = '0;
        if (h_len_o != '0) begin
            out_data_next[0]     = 1'b1;
            out_data_next[10:1]  = best_h_row_next;
            out_data_next[20:11] = h_start;
            out_data_next[30:21] = best_h_end_next;
            out_data_next[41:31] = h_len_o;
        end
        if (v_len_o != '0) begin
            out_data_next[42]    = 1'b1;
            out_data_next[52:43] = best_v_col_next;
            out_data_next[62:53] = v_start;
            out_data_next[72:63] = best_v_end_next;
            out_data_next[83:73] = v_len_o;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (s1_fire && s1_frame_end_reg) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_comb begin
        row_run_next = row_run_reg;
        if (s1_fire) begin
            row_run_next = s1_frame_end_reg ? '0 : hrun;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            row_run_reg    <= '0;
            best_h_len_reg <= '0;
            best_h_row_reg <= '0;
            best_h_end_reg <= '0;
            best_v_len_reg <= '0;
            best_v_col_reg <= '0;
            best_v_end_reg <= '0;
        end else begin
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            row_run_reg   <= row_run_next;
            if (accept) begin
                fwd_hit_reg <= s1_fire && (s1_col_reg == cur_col_reg);
            end
            if (s1_fire) begin
                if (s1_frame_end_reg) begin
                    best_h_len_reg <= '0;
                    best_h_row_reg <= '0;
                    best_h_end_reg <= '0;
                    best_v_len_reg <= '0;
                    best_v_col_reg <= '0;
                    best_v_end_reg <= '0;
                end else begin
                    best_h_len_reg <= best_h_len_next;
                    best_h_row_reg <= best_h_row_next;
                    best_h_end_reg <= best_h_end_next;
                    best_v_len_reg <= best_v_len_next;
                    best_v_col_reg <= best_v_col_next;
                    best_v_end_reg <= best_v_end_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pixel_reg     <= s_tdata[0];
            s1_col_reg       <= cur_col_reg;
            s1_row_reg       <= cur_row_reg;
            s1_frame_end_reg <= frame_end;
            fwd_data_reg     <= vrun;
        end
        if (s1_fire && s1_frame_end_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    llrf_col_ram u_col_ram (
        .aclk    (aclk),
        .wr      (col_wr),
        .rd      (col_rd),
        .rd_data (ram_rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `ASSERT_NEXT(a_fwd_same_col, aclk, aresetn,
                 accept && s1_fire && (s1_col_reg == cur_col_reg), fwd_hit_reg)
    `ASSERT_NEXT(a_frame_end_shows, aclk, aresetn, s1_fire && s1_frame_end_reg, m_tvalid)
    `ASSERT_NEXT(a_frame_end_clears, aclk, aresetn, s1_fire && s1_frame_end_reg,
                 best_h_len_reg == '0 && best_v_len_reg == '0)
    `ASSERT_SAME(a_h_len_bound, aclk, aresetn, 1'b1, best_h_len_reg <= DIM_W'(MAX_COLS))

endmodule

/* rtl/llrf_col_ram.sv */
// per-column vertical run store, one write and one registered read port
// depends on llrf_pkg
module llrf_col_ram
    import llrf_pkg::*;
(
    input  logic             aclk,
    input  col_wr_t          wr,
    input  col_rd_t          rd,
    output logic [DIM_W-1:0] rd_data
);

    logic [DIM_W-1:0] mem [MAX_COLS];
    logic [DIM_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
